[rtl/erpg_pkg.sv]
package erpg_pkg;

  localparam int MAX_DIM   = 512;
  localparam int NUM_STEPS = 6;

  localparam int XY_W   = $clog2(MAX_DIM);
  localparam int DIM_W  = 10;
  localparam int PER_W  = 8;
  localparam int V_W    = 8;
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 3;
  localparam int CFGA_W = 2;
  localparam int CFGD_W = 10;

  localparam int D_W   = 2 * XY_W + 2;
  localparam int MA_W  = 18;
  localparam int MB_W  = 19;
  localparam int P_W   = MA_W + MB_W;
  localparam int PUP_W = 13;
  localparam int INR_W = 14;
  localparam int OUT_W = 15;
  localparam int SCL_W = 16;
  localparam int NPS_W = 16;

  // reciprocal multipliers, ceil(2^k / c)
  localparam logic [MB_W-1:0] M_DIV60 = 19'd279621;  // k = 24
  localparam logic [MB_W-1:0] M_DIV30 = 19'd279621;  // k = 23
  localparam logic [MB_W-1:0] M_DIV20 = 19'd419431;  // k = 23
  localparam logic [MB_W-1:0] M_DIV3A = 19'd10923;   // k = 15
  localparam logic [MB_W-1:0] M_DIV3B = 19'd174763;  // k = 19
  localparam logic [MB_W-1:0] M_DIV5  = 19'd104858;  // k = 19

  localparam logic [CFGA_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFGA_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFGA_W-1:0] CFG_PERIOD = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [IDX_W-1:0] STEP_OPEN   = 3'd0;
  localparam logic [IDX_W-1:0] STEP_SQUINT = 3'd1;
  localparam logic [IDX_W-1:0] STEP_WIDE   = 3'd2;
  localparam logic [IDX_W-1:0] STEP_NARROW = 3'd3;
  localparam logic [IDX_W-1:0] STEP_ALT    = 3'd4;
  localparam logic [IDX_W-1:0] STEP_SLIT   = 3'd5;

  typedef enum logic [2:0] {
    SH_0  = 3'd0,
    SH_15 = 3'd1,
    SH_19 = 3'd2,
    SH_23 = 3'd3,
    SH_24 = 3'd4
  } shift_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef enum logic [3:0] {
    ST_DX2   = 4'd0,
    ST_DY2   = 4'd1,
    ST_VB    = 4'd2,
    ST_Q60   = 4'd3,
    ST_Q30   = 4'd4,
    ST_Q20   = 4'd5,
    ST_B53   = 4'd6,
    ST_SCL   = 4'd7,
    ST_PMUL  = 4'd8,
    ST_PDIV  = 4'd9,
    ST_CLASS = 4'd10
  } step_e;

  typedef struct packed {
    logic [IDX_W-1:0] anim;
    logic [D_W-1:0]   d;
    logic [PUP_W-1:0] ps;
    logic [INR_W-1:0] inner;
    logic [OUT_W-1:0] outer;
    logic [SCL_W-1:0] sclera;
    logic [XY_W-1:0]  y;
    logic [DIM_W-1:0] h;
  } pal_in_t;

endpackage

[rtl/erpg_intf.sv]
interface erpg_req_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [erpg_pkg::XY_W-1:0]    pixel_x;
  logic [erpg_pkg::XY_W-1:0]    pixel_y;
  logic [erpg_pkg::V_W-1:0]     view_dist;

  modport source (output valid, op, pixel_x, pixel_y, view_dist, input ready);
  modport sink (input valid, op, pixel_x, pixel_y, view_dist, output ready);
endinterface

interface erpg_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [erpg_pkg::PIX_W-1:0]   pixel_value;
  logic [erpg_pkg::IDX_W-1:0]   frame_index;

  modport source (output valid, pixel_value, frame_index, input ready);
  modport sink (input valid, pixel_value, frame_index, output ready);
endinterface

interface erpg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [erpg_pkg::CFGA_W-1:0]  index;
  logic [erpg_pkg::CFGD_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/eye_ring_pixel_generator.sv]
// Sequence: a tick request goes from accept straight to the output load; a pixel
//   request runs 10 shared multiply-and-shift steps, classify, then output load.
// The output load waits while the previous response is stalled; the input is ready
//   only in idle, so no new request is taken before the last result is loaded.
// Reset (rst_ni low, asynchronous): tick count and animation step clear, the
//   frame size returns to 240 x 240 and the period to 30.
module eye_ring_pixel_generator (
  input  logic           clk_i,
  input  logic           rst_ni,
  erpg_req_if.sink       req_i,
  erpg_rsp_if.source     rsp_o,
  erpg_cfg_if.sink       cfg_i
);

  erpg_pkg::state_e state_q, state_d;
  erpg_pkg::step_e  step_q;

  logic [erpg_pkg::DIM_W-1:0] width_q, height_q;
  logic [erpg_pkg::PER_W-1:0] period_q, tick_q;
  logic [erpg_pkg::IDX_W-1:0] anim_q;

  logic [erpg_pkg::XY_W-1:0]  dx_q, dy_q, y_q;
  logic [erpg_pkg::V_W-1:0]   v_q;
  logic [erpg_pkg::DIM_W-1:0] b_q;
  logic [erpg_pkg::D_W-1:0]   d_q;
  logic [erpg_pkg::MA_W-1:0]  vb_q;
  logic [erpg_pkg::PUP_W-1:0] pupil_q, ps_q;
  logic [erpg_pkg::INR_W-1:0] inner_q;
  logic [erpg_pkg::OUT_W-1:0] outer_q;
  logic [erpg_pkg::SCL_W-1:0] sclera_q;
  logic [erpg_pkg::NPS_W-1:0] n_q;
  logic [erpg_pkg::PIX_W-1:0] res_pix_q;

  logic                       out_valid_q;
  logic [erpg_pkg::PIX_W-1:0] out_pix_q;
  logic [erpg_pkg::IDX_W-1:0] out_idx_q;

  logic                       in_acc, out_load;
  logic [erpg_pkg::DIM_W:0]   wh_sum;
  logic [erpg_pkg::XY_W-1:0]  cx, cy;
  logic [12:0]                b5;
  logic [13:0]                b15;
  logic [16:0]                b125;
  logic [2:0]                 kmul;
  logic [erpg_pkg::PER_W:0]   tick_next;
  logic [erpg_pkg::IDX_W:0]   anim_next;

  logic [erpg_pkg::MA_W-1:0]  mul_a;
  logic [erpg_pkg::MB_W-1:0]  mul_b;
  erpg_pkg::shift_e           mul_sh;
  logic [erpg_pkg::P_W-1:0]   mul_p;

  erpg_pkg::pal_in_t          pal;
  logic [erpg_pkg::PIX_W-1:0] pal_pix;

  assign req_i.ready = (state_q == erpg_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == erpg_pkg::S_DONE) && (!out_valid_q || rsp_o.ready);

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.pixel_value = out_pix_q;
  assign rsp_o.frame_index = out_idx_q;

  assign wh_sum = {1'b0, width_q} + {1'b0, height_q};
  assign cx     = width_q[erpg_pkg::DIM_W-1:1];
  assign cy     = height_q[erpg_pkg::DIM_W-1:1];
  assign b5     = 13'({b_q, 2'b00}) + 13'(b_q);
  assign b15    = 14'({b_q, 4'b0000}) - 14'(b_q);
  assign b125   = 17'({b_q, 7'b0000000}) - 17'({b_q, 1'b0}) - 17'(b_q);

  assign tick_next = {1'b0, tick_q} + 9'd1;
  assign anim_next = {1'b0, anim_q} + 4'd1;

  always_comb begin
    unique case (anim_q)
      erpg_pkg::STEP_WIDE:   kmul = 3'd3;
      erpg_pkg::STEP_NARROW: kmul = 3'd4;
      erpg_pkg::STEP_SLIT:   kmul = 3'd6;
      default:               kmul = 3'd5;
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = erpg_pkg::SH_0;
    unique case (step_q)
      erpg_pkg::ST_DX2: begin
        mul_a = erpg_pkg::MA_W'(dx_q);
        mul_b = erpg_pkg::MB_W'(dx_q);
      end
      erpg_pkg::ST_DY2: begin
        mul_a = erpg_pkg::MA_W'(dy_q);
        mul_b = erpg_pkg::MB_W'(dy_q);
      end
      erpg_pkg::ST_VB: begin
        mul_a = erpg_pkg::MA_W'(v_q);
        mul_b = erpg_pkg::MB_W'(b_q);
      end
      erpg_pkg::ST_Q60: begin
        mul_a  = vb_q;
        mul_b  = erpg_pkg::M_DIV60;
        mul_sh = erpg_pkg::SH_24;
      end
      erpg_pkg::ST_Q30: begin
        mul_a  = vb_q;
        mul_b  = erpg_pkg::M_DIV30;
        mul_sh = erpg_pkg::SH_23;
      end
      erpg_pkg::ST_Q20: begin
        mul_a  = vb_q;
        mul_b  = erpg_pkg::M_DIV20;
        mul_sh = erpg_pkg::SH_23;
      end
      erpg_pkg::ST_B53: begin
        mul_a  = erpg_pkg::MA_W'(b5);
        mul_b  = erpg_pkg::M_DIV3A;
        mul_sh = erpg_pkg::SH_15;
      end
      erpg_pkg::ST_SCL: begin
        mul_a  = erpg_pkg::MA_W'(b125);
        mul_b  = erpg_pkg::M_DIV3B;
        mul_sh = erpg_pkg::SH_19;
      end
      erpg_pkg::ST_PMUL: begin
        mul_a = erpg_pkg::MA_W'(pupil_q);
        mul_b = erpg_pkg::MB_W'(kmul);
      end
      erpg_pkg::ST_PDIV: begin
        mul_a  = erpg_pkg::MA_W'(n_q);
        mul_b  = erpg_pkg::M_DIV5;
        mul_sh = erpg_pkg::SH_19;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  erpg_mul_unit u_mul (
    .a_i  (mul_a),
    .b_i  (mul_b),
    .sh_i (mul_sh),
    .p_o  (mul_p)
  );

  assign pal.anim   = anim_q;
  assign pal.d      = d_q;
  assign pal.ps     = ps_q;
  assign pal.inner  = inner_q;
  assign pal.outer  = outer_q;
  assign pal.sclera = sclera_q;
  assign pal.y      = y_q;
  assign pal.h      = height_q;

  erpg_palette u_pal (
    .pal_i   (pal),
    .pixel_o (pal_pix)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      erpg_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (req_i.op == erpg_pkg::OP_PIXEL) ? erpg_pkg::S_CALC : erpg_pkg::S_DONE;
        end
      end
      erpg_pkg::S_CALC: begin
        if (step_q == erpg_pkg::ST_CLASS) state_d = erpg_pkg::S_DONE;
      end
      erpg_pkg::S_DONE: begin
        if (out_load) state_d = erpg_pkg::S_IDLE;
      end
      default: state_d = erpg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= erpg_pkg::S_IDLE;
      step_q      <= erpg_pkg::ST_DX2;
      width_q     <= 10'd240;
      height_q    <= 10'd240;
      period_q    <= 8'd30;
      tick_q      <= '0;
      anim_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          erpg_pkg::CFG_WIDTH:  width_q  <= cfg_i.data;
          erpg_pkg::CFG_HEIGHT: height_q <= cfg_i.data;
          erpg_pkg::CFG_PERIOD: period_q <= cfg_i.data[erpg_pkg::PER_W-1:0];
          default: ;
        endcase
      end

      if (in_acc && req_i.op == erpg_pkg::OP_TICK) begin
        if (tick_next >= {1'b0, period_q}) begin
          tick_q <= '0;
          anim_q <= (anim_next >= 4'(erpg_pkg::NUM_STEPS)) ? '0 : anim_next[erpg_pkg::IDX_W-1:0];
        end else begin
          tick_q <= tick_next[erpg_pkg::PER_W-1:0];
        end
      end

      if (in_acc) begin
        step_q <= erpg_pkg::ST_DX2;
      end else if (state_q == erpg_pkg::S_CALC && step_q != erpg_pkg::ST_CLASS) begin
        step_q <= erpg_pkg::step_e'(step_q + 4'd1);
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q      <= (req_i.pixel_x > cx) ? req_i.pixel_x - cx : cx - req_i.pixel_x;
      dy_q      <= (req_i.pixel_y > cy) ? req_i.pixel_y - cy : cy - req_i.pixel_y;
      y_q       <= req_i.pixel_y;
      v_q       <= req_i.view_dist;
      b_q       <= wh_sum[erpg_pkg::DIM_W:1];
      res_pix_q <= '0;
    end
    if (state_q == erpg_pkg::S_CALC) begin
      unique case (step_q)
        erpg_pkg::ST_DX2:  d_q      <= mul_p[erpg_pkg::D_W-1:0];
        erpg_pkg::ST_DY2:  d_q      <= d_q + mul_p[erpg_pkg::D_W-1:0];
        erpg_pkg::ST_VB:   vb_q     <= mul_p[erpg_pkg::MA_W-1:0];
        erpg_pkg::ST_Q60:  pupil_q  <= mul_p[erpg_pkg::PUP_W-1:0];
        erpg_pkg::ST_Q30:  inner_q  <= mul_p[erpg_pkg::INR_W-1:0];
        erpg_pkg::ST_Q20:  outer_q  <= mul_p[erpg_pkg::OUT_W-1:0];
        erpg_pkg::ST_B53: begin
          pupil_q <= pupil_q + mul_p[erpg_pkg::PUP_W-1:0];
          inner_q <= inner_q + erpg_pkg::INR_W'(b5);
          outer_q <= outer_q + erpg_pkg::OUT_W'(b15);
        end
        erpg_pkg::ST_SCL:  sclera_q <= mul_p[erpg_pkg::SCL_W-1:0];
        erpg_pkg::ST_PMUL: n_q      <= mul_p[erpg_pkg::NPS_W-1:0];
        erpg_pkg::ST_PDIV: ps_q     <= mul_p[erpg_pkg::PUP_W-1:0];
        erpg_pkg::ST_CLASS: res_pix_q <= pal_pix;
        default: ;
      endcase
    end
    if (out_load) begin
      out_pix_q <= res_pix_q;
      out_idx_q <= anim_q;
    end
  end

endmodule

[rtl/erpg_mul_unit.sv]
module erpg_mul_unit (
  input  logic [erpg_pkg::MA_W-1:0] a_i,
  input  logic [erpg_pkg::MB_W-1:0] b_i,
  input  erpg_pkg::shift_e          sh_i,
  output logic [erpg_pkg::P_W-1:0]  p_o
);

  logic [erpg_pkg::P_W-1:0] prod;

  assign prod = erpg_pkg::P_W'(a_i) * erpg_pkg::P_W'(b_i);

  always_comb begin
    unique case (sh_i)
      erpg_pkg::SH_0:  p_o = prod;
      erpg_pkg::SH_15: p_o = prod >> 15;
      erpg_pkg::SH_19: p_o = prod >> 19;
      erpg_pkg::SH_23: p_o = prod >> 23;
      erpg_pkg::SH_24: p_o = prod >> 24;
      default:         p_o = prod;
    endcase
  end

endmodule

[rtl/erpg_palette.sv]
module erpg_palette (
  input  erpg_pkg::pal_in_t            pal_i,
  output logic [erpg_pkg::PIX_W-1:0]   pixel_o
);

  logic        lt_p, lt_i, lt_o, lt_s, lt_i45, lt_s65;
  logic [21:0] d5, i4, s6;
  logic [16:0] y5, y10, y100, h1, h4, h3, h7, h17, h83;
  logic        band1, band3, band5;

  always_comb begin
    lt_p   = pal_i.d < erpg_pkg::D_W'(pal_i.ps);
    lt_i   = pal_i.d < erpg_pkg::D_W'(pal_i.inner);
    lt_o   = pal_i.d < erpg_pkg::D_W'(pal_i.outer);
    lt_s   = pal_i.d < erpg_pkg::D_W'(pal_i.sclera);
    d5     = 22'(pal_i.d) * 22'd5;
    i4     = 22'(pal_i.inner) * 22'd4;
    s6     = 22'(pal_i.sclera) * 22'd6;
    lt_i45 = d5 < i4;
    lt_s65 = d5 < s6;

    y5   = 17'(pal_i.y) * 17'd5;
    y10  = 17'(pal_i.y) * 17'd10;
    y100 = 17'(pal_i.y) * 17'd100;
    h1   = 17'(pal_i.h);
    h4   = 17'(pal_i.h) * 17'd4;
    h3   = 17'(pal_i.h) * 17'd3;
    h7   = 17'(pal_i.h) * 17'd7;
    h17  = 17'(pal_i.h) * 17'd17;
    h83  = 17'(pal_i.h) * 17'd83;
    band1 = (y5 > h1) && (y5 < h4);
    band3 = (y10 > h3) && (y10 < h7);
    band5 = (y100 > h17) && (y100 < h83);

    unique case (pal_i.anim)
      erpg_pkg::STEP_OPEN: begin
        if (lt_p) pixel_o = 8'd0;
        else if (lt_i) pixel_o = 8'd96;
        else if (lt_o) pixel_o = 8'd64;
        else if (lt_s) pixel_o = 8'd255;
        else pixel_o = 8'd0;
      end
      erpg_pkg::STEP_SQUINT: begin
        if (!band1) pixel_o = 8'd0;
        else if (lt_p) pixel_o = 8'd0;
        else if (lt_i) pixel_o = 8'd128;
        else if (lt_o) pixel_o = 8'd96;
        else pixel_o = 8'd224;
      end
      erpg_pkg::STEP_WIDE: begin
        if (lt_p) pixel_o = 8'd0;
        else if (lt_i45) pixel_o = 8'd160;
        else if (lt_o) pixel_o = 8'd128;
        else if (lt_s65) pixel_o = 8'd255;
        else pixel_o = 8'd32;
      end
      erpg_pkg::STEP_NARROW: begin
        if (!band3) pixel_o = 8'd16;
        else if (lt_p) pixel_o = 8'd0;
        else if (lt_i) pixel_o = 8'd96;
        else pixel_o = 8'd192;
      end
      erpg_pkg::STEP_ALT: begin
        if (lt_p) pixel_o = 8'd0;
        else if (lt_i) pixel_o = 8'd64;
        else if (lt_o) pixel_o = 8'd224;
        else if (lt_s) pixel_o = 8'd255;
        else pixel_o = 8'd0;
      end
      erpg_pkg::STEP_SLIT: begin
        if (!band5) pixel_o = 8'd0;
        else if (lt_p) pixel_o = 8'd0;
        else if (lt_o) pixel_o = 8'd192;
        else pixel_o = 8'd255;
      end
      default: pixel_o = 8'd0;
    endcase
  end

endmodule

[rtl/erpg_checker.sv]
module erpg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [erpg_pkg::PIX_W-1:0]   rsp_pixel,
  input logic [erpg_pkg::IDX_W-1:0]   rsp_index
);

  logic [1:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = req_valid && req_ready;
  assign out_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_index))
    else $error("response dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !req_ready)
    else $error("request taken while previous one in progress");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_index < 3'(erpg_pkg::NUM_STEPS))
    else $error("frame index out of range");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> pending_q != 2'd0)
    else $error("response without an outstanding request");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many outstanding requests");

endmodule

bind eye_ring_pixel_generator erpg_checker u_erpg_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_pixel (rsp_o.pixel_value),
  .rsp_index (rsp_o.frame_index)
);
